// File: src/ps2mc_pkg.sv
`default_nettype none

package ps2mc_pkg;

   // Widths fixed by the byte stream and the register file
   localparam int ByteW = 8;
   localparam int SizeW = 13;

   // Flags byte bit positions
   localparam int FlagLeftBit   = 0;
   localparam int FlagRightBit  = 1;
   localparam int FlagMiddleBit = 2;
   localparam int FlagSyncBit   = 3;
   localparam int FlagOvfXBit   = 6;
   localparam int FlagOvfYBit   = 7;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [SizeW-1:0] ScreenWidthReset  = 13'd640;
   localparam logic [SizeW-1:0] ScreenHeightReset = 13'd480;

   // Packet byte position
   typedef enum logic [2:0] {
      PH_FLAGS   = 3'b001,
      PH_DELTA_X = 3'b010,
      PH_DELTA_Y = 3'b100
   } phase_type;

   // Packet assembly state carried between requests
   typedef struct packed {
      phase_type        phase;
      logic [ByteW-1:0] flags;
      logic [ByteW-1:0] delta_x;
   } pkt_ctl_type;

endpackage

`default_nettype wire

// File: src/ps2mc_step.sv
`default_nettype none

module ps2mc_step
   import ps2mc_pkg::*;
#(
   parameter int COORD_WIDTH = 12
) (
   input  wire logic [ByteW-1:0]       rx_byte,
   input  wire pkt_ctl_type            ctl_ff,
   input  wire logic [COORD_WIDTH-1:0] pos_x_ff,
   input  wire logic [COORD_WIDTH-1:0] pos_y_ff,
   input  wire logic [SizeW-1:0]       screen_width,
   input  wire logic [SizeW-1:0]       screen_height,
   output pkt_ctl_type                 ctl_in,
   output logic [COORD_WIDTH-1:0]      pos_x_in,
   output logic [COORD_WIDTH-1:0]      pos_y_in,
   output logic                        moved
);

   localparam int SumW = COORD_WIDTH + 2;
   localparam int CmpW = (SumW > SizeW + 1) ? SumW : SizeW + 1;

   // Add a signed byte delta to a coordinate and clamp to 0 .. size-1, capped at the coordinate maximum
   function automatic logic [COORD_WIDTH-1:0] advance(
      input logic [COORD_WIDTH-1:0] pos,
      input logic [ByteW-1:0]       delta,
      input logic [SizeW-1:0]       size
   );
      logic [SumW-1:0]  sum;
      logic [SizeW-1:0] size_m1;
      logic [CmpW-1:0]  lim;
      logic [CmpW-1:0]  coord_max;
      logic [COORD_WIDTH-1:0] res;
      sum = {2'b00, pos} + {{(SumW-ByteW){delta[ByteW-1]}}, delta};
      size_m1 = (size == '0) ? '0 : size - SizeW'(1);
      coord_max = CmpW'({COORD_WIDTH{1'b1}});
      lim = (CmpW'(size_m1) > coord_max) ? coord_max : CmpW'(size_m1);
      if (sum[SumW-1]) begin
         res = '0;
      end else if (CmpW'(sum) >= lim) begin
         res = lim[COORD_WIDTH-1:0];
      end else begin
         res = sum[COORD_WIDTH-1:0];
      end
      return res;
   endfunction

   logic [ByteW-1:0] delta_y;

   // Y axis points up on the mouse: negate with 8-bit wrap
   assign delta_y = ByteW'(0) - rx_byte;

   // Advance the packet one byte
   always_comb begin
      ctl_in   = ctl_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      moved    = 1'b0;
      unique case (ctl_ff.phase)
         PH_DELTA_X: begin
            ctl_in.delta_x = rx_byte;
            ctl_in.phase   = PH_DELTA_Y;
         end
         PH_DELTA_Y: begin
            ctl_in.phase = PH_FLAGS;
            // drop the packet on either overflow flag
            if (!ctl_ff.flags[FlagOvfXBit] && !ctl_ff.flags[FlagOvfYBit]) begin
               pos_x_in = advance(pos_x_ff, ctl_ff.delta_x, screen_width);
               pos_y_in = advance(pos_y_ff, delta_y, screen_height);
               moved    = 1'b1;
            end
         end
         default: begin
            // flags byte: always stored, advance only when in sync
            ctl_in.flags = rx_byte;
            ctl_in.phase = rx_byte[FlagSyncBit] ? PH_DELTA_X : PH_FLAGS;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: src/ps2_mouse_packet_cursor_core.sv
// Latency: a response is valid the cycle after its request is accepted.
// Throughput: one request per cycle while no response is stalled; a new byte is taken while the previous
// response is being read, the response register is the only stage.
// Reset (synchronous): packet phase returns to PH_FLAGS; flags, delta X and cursor clear to zero,
// screen size returns to 640 x 480, and the response register empties.
`default_nettype none

module ps2_mouse_packet_cursor_core
   import ps2mc_pkg::*;
#(
   parameter int COORD_WIDTH = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [ByteW-1:0]       req_rx_byte,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [COORD_WIDTH-1:0]      rsp_cursor_x,
   output logic [COORD_WIDTH-1:0]      rsp_cursor_y,
   output logic                        rsp_button_left,
   output logic                        rsp_button_right,
   output logic                        rsp_button_middle,
   output logic                        rsp_moved,
   // register writes
   input  wire logic                   csr_we,
   input  wire logic [0:0]             csr_index,
   input  wire logic [SizeW-1:0]       csr_wdata
);

   logic [SizeW-1:0]       screen_width_ff;
   logic [SizeW-1:0]       screen_height_ff;
   pkt_ctl_type            ctl_ff;
   pkt_ctl_type            ctl_in;
   logic [COORD_WIDTH-1:0] pos_x_ff;
   logic [COORD_WIDTH-1:0] pos_x_in;
   logic [COORD_WIDTH-1:0] pos_y_ff;
   logic [COORD_WIDTH-1:0] pos_y_in;
   logic                   moved_in;
   logic                   rsp_valid_ff;
   logic                   rsp_moved_ff;
   logic [COORD_WIDTH-1:0] rsp_cursor_x_ff;
   logic [COORD_WIDTH-1:0] rsp_cursor_y_ff;
   logic [2:0]             rsp_buttons_ff;
   logic                   req_take;

   // Hold off requests only while a response waits and is not being taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= ScreenWidthReset;
         screen_height_ff <= ScreenHeightReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ps2mc_step #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_step (
      .rx_byte       (req_rx_byte),
      .ctl_ff        (ctl_ff),
      .pos_x_ff      (pos_x_ff),
      .pos_y_ff      (pos_y_ff),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .ctl_in        (ctl_in),
      .pos_x_in      (pos_x_in),
      .pos_y_in      (pos_y_in),
      .moved         (moved_in)
   );

   // Advance packet state and cursor on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.phase   <= PH_FLAGS;
         ctl_ff.flags   <= '0;
         ctl_ff.delta_x <= '0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
      end else if (req_take) begin
         ctl_ff   <= ctl_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   // Response register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_cursor_x_ff <= pos_x_in;
         rsp_cursor_y_ff <= pos_y_in;
         rsp_buttons_ff  <= {ctl_in.flags[FlagMiddleBit], ctl_in.flags[FlagRightBit],
                             ctl_in.flags[FlagLeftBit]};
         rsp_moved_ff    <= moved_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_x      = rsp_cursor_x_ff;
   assign rsp_cursor_y      = rsp_cursor_y_ff;
   assign rsp_button_left   = rsp_buttons_ff[0];
   assign rsp_button_right  = rsp_buttons_ff[1];
   assign rsp_button_middle = rsp_buttons_ff[2];
   assign rsp_moved         = rsp_moved_ff;

endmodule

`default_nettype wire

// File: src/ps2mc_checker.sv
`default_nettype none

module ps2mc_checker #(
   parameter int COORD_WIDTH = 12
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [COORD_WIDTH-1:0] rsp_cursor_x,
   input wire logic [COORD_WIDTH-1:0] rsp_cursor_y,
   input wire logic                   rsp_moved
);

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every accepted request shows up as a response next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request produced no response");

   // Requests are held off only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a waiting response");

   // A stalled response stays valid and holds its cursor and moved flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_cursor_x) && $stable(rsp_cursor_y) && $stable(rsp_moved)))
      else $error("stalled response changed");

endmodule

bind ps2_mouse_packet_cursor_core ps2mc_checker #(
   .COORD_WIDTH(COORD_WIDTH)
) u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_cursor_x (rsp_cursor_x),
   .rsp_cursor_y (rsp_cursor_y),
   .rsp_moved    (rsp_moved)
);

`default_nettype wire
